>>> sv/svalloc_pkg.sv
// Shared types, codes and helpers for the synth voice allocator.
// No dependencies; used by synth_voice_allocator.
package svalloc_pkg;

    localparam int CHIP_COUNT_DEF  = 4;
    localparam int VOICES_PER_CHIP = 6;
    localparam int KEY_W           = 7;
    // widest voice number over the supported chip counts (up to 8 chips of 6)
    localparam int MAX_VOICE_W     = 6;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [2:0] chip;
        logic [2:0] chan;
    } voice_loc_t;

    // voice / 6 as (v * 43) >> 8, exact for v < 48; remainder by subtraction
    function automatic voice_loc_t voice_split(input logic [MAX_VOICE_W-1:0] v);
        logic [11:0] prod;
        logic [2:0]  c;
        logic [5:0]  c6;
        logic [5:0]  rem;
        voice_loc_t  r;
        prod   = {6'd0, v} * 12'd43;
        c      = prod[10:8];
        c6     = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
        rem    = v - c6;
        r.chip = c;
        r.chan = rem[2:0];
        return r;
    endfunction

endpackage

>>> sv/synth_voice_allocator.sv
// Synth voice allocator: note events in, voice assignment words out.
// Depends on svalloc_pkg (codes, voice number split).
//
// Usage:
//   Input channel s_axis: tdata carries the key, tuser the note-on flag.
//   Output channel m_axis: one word per input event; tuser carries the
//   action code, tdata the chip, channel, reload and steal information.
//   Per-voice busy and previous keys live in one synchronous RAM; a
//   valid bit per voice makes unwritten entries read as zero.
//   Each event scans every voice once through the RAM read port, then
//   the commit state writes back the chosen voice, if any, and loads the output register.
//   A new event is accepted only in the idle state, after the previous
//   event has been committed, so the scans of two events never overlap;
//   each scan is limited by the single RAM read port.
//   Reset clears the valid bits, the round-robin pointer and control state,
//   so every voice is free straight after reset; no clearing pass is needed.
//   When the receiver stalls, the result is held in the output register and
//   the next event may still be accepted and scanned; its write-back waits
//   until the held word is taken.
module synth_voice_allocator #(
    parameter int CHIP_COUNT = svalloc_pkg::CHIP_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] key, [7] zero pad
    input  logic        s_axis_tuser,   // [0] note_on
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] chip_index, [5:3] channel_in_chip,
                                        // [6] needs_reload, [7] stole_voice,
                                        // [14:8] stolen_key, [15] zero pad
    output logic [1:0]  m_axis_tuser    // [1:0] action
);

    localparam int VOICE_COUNT = CHIP_COUNT * svalloc_pkg::VOICES_PER_CHIP;
    localparam int VW          = $clog2(VOICE_COUNT);
    localparam int CW          = $clog2(VOICE_COUNT + 1);
    localparam int KW          = svalloc_pkg::KEY_W;
    localparam int MW          = svalloc_pkg::MAX_VOICE_W;

    svalloc_pkg::state_t state_reg, state_next;

    // voice RAM: {previous_key, busy_key}
    logic [2*KW-1:0]        mem [VOICE_COUNT];
    logic [2*KW-1:0]        rdata_reg;
    logic [VOICE_COUNT-1:0] vld_reg;

    logic          on_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] ptr_reg, ptr_next;

    logic [CW-1:0] rd_cnt_reg;
    logic          pend_reg;
    logic [VW-1:0] pend_idx_reg;

    // scan trackers
    logic          reuse_found_reg, freehi_found_reg, freelo_found_reg, off_found_reg;
    logic [VW-1:0] reuse_idx_reg, freehi_idx_reg, freelo_idx_reg, off_idx_reg;
    logic [KW-1:0] ptr_key_reg, off_prev_reg;

    logic          issue, commit, accept;
    logic [KW-1:0] e_busy, e_prev;
    logic          last_read;

    // commit decisions
    svalloc_pkg::action_t act;
    logic [VW-1:0]   sel_v;
    logic            reload, stole;
    logic [KW-1:0]   sk;
    logic [2*KW-1:0] wdata;
    logic            mem_we;
    svalloc_pkg::voice_loc_t loc;

    logic          m_valid_reg;
    logic [15:0]   m_data_reg;
    logic [1:0]    m_user_reg;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign e_busy = vld_reg[pend_idx_reg] ? rdata_reg[KW-1:0]    : '0;
    assign e_prev = vld_reg[pend_idx_reg] ? rdata_reg[2*KW-1:KW] : '0;
    assign last_read = pend_reg && (pend_idx_reg == VW'(VOICE_COUNT - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            svalloc_pkg::ST_IDLE:   if (s_axis_tvalid) state_next = svalloc_pkg::ST_SCAN;
            svalloc_pkg::ST_SCAN:   if (last_read) state_next = svalloc_pkg::ST_COMMIT;
            svalloc_pkg::ST_COMMIT: if (commit) state_next = svalloc_pkg::ST_IDLE;
            default:                state_next = svalloc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        commit        = 1'b0;
        unique case (state_reg)
            svalloc_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            svalloc_pkg::ST_SCAN:   issue = (rd_cnt_reg < CW'(VOICE_COUNT));
            svalloc_pkg::ST_COMMIT: commit = !m_valid_reg || m_axis_tready;
            default:                s_axis_tready = 1'b0;
        endcase
    end

    // choose voice and write-back word
    always_comb begin
        act    = svalloc_pkg::ACT_NONE;
        sel_v  = '0;
        reload = 1'b0;
        stole  = 1'b0;
        sk     = '0;
        wdata  = {key_reg, key_reg};
        mem_we = 1'b0;
        if (on_reg) begin
            act    = svalloc_pkg::ACT_START;
            mem_we = commit;
            reload = 1'b1;
            priority if (reuse_found_reg) begin
                sel_v  = reuse_idx_reg;
                reload = 1'b0;
            end else if (freehi_found_reg) begin
                sel_v = freehi_idx_reg;
            end else if (freelo_found_reg) begin
                // free voice only below the pointer: the scan wrapped round
                sel_v = freelo_idx_reg;
            end else begin
                sel_v = ptr_reg;
                stole = 1'b1;
                sk    = ptr_key_reg;
            end
        end else if (off_found_reg) begin
            act    = svalloc_pkg::ACT_STOP;
            sel_v  = off_idx_reg;
            wdata  = {off_prev_reg, {KW{1'b0}}};
            mem_we = commit;
        end
    end

    assign ptr_next = (sel_v == VW'(VOICE_COUNT - 1)) ? '0 : sel_v + 1'b1;
    assign loc      = svalloc_pkg::voice_split(MW'(sel_v));

    // voice RAM
    always_ff @(posedge aclk) begin
        if (issue)
            rdata_reg <= mem[rd_cnt_reg[VW-1:0]];
        if (mem_we)
            mem[sel_v] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= svalloc_pkg::ST_IDLE;
            vld_reg     <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (mem_we)
                vld_reg[sel_v] <= 1'b1;
            if (commit && on_reg)
                ptr_reg <= ptr_next;
            if (commit)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload and scan trackers
    always_ff @(posedge aclk) begin
        if (accept) begin
            on_reg           <= s_axis_tuser;
            key_reg          <= s_axis_tdata[KW-1:0];
            rd_cnt_reg       <= '0;
            reuse_found_reg  <= 1'b0;
            freehi_found_reg <= 1'b0;
            freelo_found_reg <= 1'b0;
            off_found_reg    <= 1'b0;
        end
        if (issue) begin
            rd_cnt_reg   <= rd_cnt_reg + 1'b1;
            pend_idx_reg <= rd_cnt_reg[VW-1:0];
        end
        if (pend_reg) begin
            if (!reuse_found_reg && e_prev == key_reg && e_busy == '0) begin
                reuse_found_reg <= 1'b1;
                reuse_idx_reg   <= pend_idx_reg;
            end
            if (!freehi_found_reg && e_busy == '0 && pend_idx_reg >= ptr_reg) begin
                freehi_found_reg <= 1'b1;
                freehi_idx_reg   <= pend_idx_reg;
            end
            if (!freelo_found_reg && e_busy == '0) begin
                freelo_found_reg <= 1'b1;
                freelo_idx_reg   <= pend_idx_reg;
            end
            if (pend_idx_reg == ptr_reg)
                ptr_key_reg <= e_busy;
            if (!off_found_reg && e_busy == key_reg) begin
                off_found_reg <= 1'b1;
                off_idx_reg   <= pend_idx_reg;
                off_prev_reg  <= e_prev;
            end
        end
        if (commit) begin
            m_user_reg <= act;
            m_data_reg <= {1'b0, sk, stole, reload, loc.chan, loc.chip};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // checks
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg < VW'(VOICE_COUNT - 1) || ptr_reg == VW'(VOICE_COUNT - 1))
        else $error("round-robin pointer out of range");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == svalloc_pkg::ST_SCAN)
        else $error("accepted word did not start a scan");

    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> state_reg == svalloc_pkg::ST_SCAN)
        else $error("RAM read data outside scan");

    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_axis_tvalid && state_reg == svalloc_pkg::ST_IDLE)
        else $error("commit did not present a result");

endmodule

>>> tb/sv/synth_voice_allocator_tb.sv
// Self-checking bench for synth_voice_allocator: note events in, voice words out.
// Depends on svalloc_pkg and the allocator RTL. The expected words come from a local
// copy of the voice tables that is updated as each note event is accepted.
`timescale 1ns / 1ps

module synth_voice_allocator_tb;

    localparam int KEY_W      = svalloc_pkg::KEY_W;
    localparam int NVOICE     = svalloc_pkg::CHIP_COUNT_DEF * svalloc_pkg::VOICES_PER_CHIP;
    localparam int N_RANDOM   = 2000;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic             note_on;
        logic [KEY_W-1:0] key;
    } note_evt_t;

    typedef struct {
        svalloc_pkg::action_t action;
        logic [2:0]           chip;
        logic [2:0]           chan;
        logic                 reload;
        logic                 stole;
        logic [KEY_W-1:0]     stolen_key;
    } voice_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    synth_voice_allocator #(.CHIP_COUNT(svalloc_pkg::CHIP_COUNT_DEF)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // local voice tables
    logic [KEY_W-1:0] vt_busy [NVOICE];
    logic [KEY_W-1:0] vt_prev [NVOICE];
    int               rr_ptr;

    note_evt_t   note_q[$];
    voice_word_t voice_q[$];
    int          err_cnt = 0;
    int          words_seen = 0;
    int          hold_left = 0;
    int          hold_mark = -1;
    bit          s_flow = 1'b0;    // sender never idles
    bit          m_flow = 1'b0;    // receiver never stalls

    function automatic int draw_gap(bit flow);
        return flow ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic voice_word_t alloc_voice(note_evt_t ev);
        voice_word_t      r;
        int               v;
        logic             reuse;
        logic [KEY_W-1:0] old;
        r.action     = svalloc_pkg::ACT_NONE;
        r.chip       = '0;
        r.chan       = '0;
        r.reload     = 1'b0;
        r.stole      = 1'b0;
        r.stolen_key = '0;
        if (ev.note_on) begin
            reuse = 1'b0;
            v = rr_ptr;
            for (int i = 0; i < NVOICE; i++) begin
                if (!reuse && vt_prev[i] == ev.key && vt_busy[i] == '0) begin
                    v = i;
                    reuse = 1'b1;
                end
            end
            if (!reuse) begin
                // round-robin search; falls back to stealing at the start point
                for (int i = 0; i < NVOICE; i++) begin
                    if (vt_busy[v] == '0)
                        break;
                    v = (v + 1) % NVOICE;
                end
            end
            old = vt_busy[v];
            vt_busy[v] = ev.key;
            vt_prev[v] = ev.key;
            rr_ptr = (v + 1) % NVOICE;
            r.action     = svalloc_pkg::ACT_START;
            r.chip       = 3'(v / svalloc_pkg::VOICES_PER_CHIP);
            r.chan       = 3'(v % svalloc_pkg::VOICES_PER_CHIP);
            r.reload     = !reuse;
            r.stole      = (old != '0);
            r.stolen_key = old;
        end else begin
            for (int i = 0; i < NVOICE; i++) begin
                if (vt_busy[i] == ev.key) begin
                    vt_busy[i] = '0;
                    r.action = svalloc_pkg::ACT_STOP;
                    r.chip   = 3'(i / svalloc_pkg::VOICES_PER_CHIP);
                    r.chan   = 3'(i % svalloc_pkg::VOICES_PER_CHIP);
                    break;
                end
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin : drv
        int   wait_n;
        logic nv;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            wait_n = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                voice_q.push_back(alloc_voice(note_q[0]));
                void'(note_q.pop_front());
                wait_n = draw_gap(s_flow);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                nv = 1'b1;
            end else if (wait_n == 0 && note_q.size() > 0) begin
                nv = 1'b1;
                s_axis_tdata <= {1'b0, note_q[0].key};
                s_axis_tuser <= note_q[0].note_on;
            end else begin
                nv = 1'b0;
                if (wait_n > 0)
                    wait_n--;
            end
            s_axis_tvalid <= nv;
        end
    end

    // long receiver hold-off so that the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if ((words_seen == 300 || words_seen == 1500) && hold_mark != words_seen) begin
            hold_left <= HOLD_LEN;
            hold_mark <= words_seen;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor and checker
    always @(posedge aclk) begin : mon
        int          stall_n;
        logic        nr;
        voice_word_t exp_w;
        voice_word_t got;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_n = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.action     = svalloc_pkg::action_t'(m_axis_tuser);
                got.chip       = m_axis_tdata[2:0];
                got.chan       = m_axis_tdata[5:3];
                got.reload     = m_axis_tdata[6];
                got.stole      = m_axis_tdata[7];
                got.stolen_key = m_axis_tdata[14:8];
                if (voice_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORT)
                        $display("%0t: unexpected word act=%0d chip=%0d chan=%0d",
                                 $time, got.action, got.chip, got.chan);
                end else begin
                    exp_w = voice_q.pop_front();
                    if (got.action !== exp_w.action || got.chip !== exp_w.chip ||
                        got.chan !== exp_w.chan || got.reload !== exp_w.reload ||
                        got.stole !== exp_w.stole || got.stolen_key !== exp_w.stolen_key) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORT)
                            $display({"%0t: word %0d mismatch exp act=%0d chip=%0d chan=%0d ",
                                      "rld=%0b stl=%0b sk=%0d got act=%0d chip=%0d chan=%0d ",
                                      "rld=%0b stl=%0b sk=%0d"},
                                     $time, words_seen, exp_w.action, exp_w.chip, exp_w.chan,
                                     exp_w.reload, exp_w.stole, exp_w.stolen_key, got.action,
                                     got.chip, got.chan, got.reload, got.stole, got.stolen_key);
                    end
                end
                words_seen <= words_seen + 1;
                stall_n = draw_gap(m_flow);
            end
            if (hold_left > 0) begin
                nr = 1'b0;
            end else if (stall_n == 0) begin
                nr = 1'b1;
            end else begin
                nr = 1'b0;
                stall_n--;
            end
            m_axis_tready <= nr;
        end
    end

    function automatic note_evt_t mk_note(logic on, int k);
        note_evt_t e;
        e.note_on = on;
        e.key     = KEY_W'(k);
        return e;
    endfunction

    initial begin : stim
        int               made;
        int               p_on;
        int               idx;
        logic [KEY_W-1:0] held[$];
        note_evt_t        e;
        for (int i = 0; i < NVOICE; i++) begin
            vt_busy[i] = '0;
            vt_prev[i] = '0;
        end
        rr_ptr = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: unmatched release, key 0 both ways, extremes, reuse of a freed voice
        note_q.push_back(mk_note(1'b0, 5));
        note_q.push_back(mk_note(1'b1, 0));
        note_q.push_back(mk_note(1'b0, 0));
        note_q.push_back(mk_note(1'b1, 127));
        note_q.push_back(mk_note(1'b1, 127));
        note_q.push_back(mk_note(1'b0, 127));
        note_q.push_back(mk_note(1'b1, 127));
        note_q.push_back(mk_note(1'b1, 0));
        note_q.push_back(mk_note(1'b0, 1));
        note_q.push_back(mk_note(1'b1, 64));
        note_q.push_back(mk_note(1'b1, 1));
        note_q.push_back(mk_note(1'b1, 42));
        note_q.push_back(mk_note(1'b1, 85));
        note_q.push_back(mk_note(1'b0, 64));
        note_q.push_back(mk_note(1'b1, 64));
        note_q.push_back(mk_note(1'b0, 127));
        note_q.push_back(mk_note(1'b0, 127));
        note_q.push_back(mk_note(1'b0, 127));
        note_q.push_back(mk_note(1'b0, 0));
        note_q.push_back(mk_note(1'b1, 0));

        // random: chunks with varying note-on density; releases mostly hit held keys
        made = 0;
        while (made < N_RANDOM) begin
            while (note_q.size() > 8)
                @(negedge aclk);
            s_flow = ($urandom_range(0, 3) == 0);
            m_flow = ($urandom_range(0, 3) == 0);
            p_on = $urandom_range(30, 85);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(1, 100) <= p_on) begin
                    e.note_on = 1'b1;
                    case ($urandom_range(0, 19))
                        0:       e.key = '0;
                        1, 2, 3,
                        4, 5:    e.key = KEY_W'($urandom_range(1, 127));
                        default: e.key = KEY_W'($urandom_range(36, 60));
                    endcase
                    held.push_back(e.key);
                    if (held.size() > 40)
                        void'(held.pop_front());
                end else begin
                    e.note_on = 1'b0;
                    if (held.size() > 0 && $urandom_range(0, 3) != 0) begin
                        idx = $urandom_range(0, held.size() - 1);
                        e.key = held[idx];
                        held.delete(idx);
                    end else begin
                        e.key = KEY_W'($urandom_range(0, 127));
                    end
                end
                note_q.push_back(e);
            end
            made += 100;
        end

        while (note_q.size() != 0 || voice_q.size() != 0)
            @(negedge aclk);
        // past the block's event latency, to catch stray words
        repeat (60) @(negedge aclk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
